FILE: src/lcw_pkg.sv
`timescale 1ns / 1ps

package lcw_pkg;

   // Field and register widths.
   localparam int SAMPLE_W  = 12;
   localparam int MV_W      = 12;
   localparam int SUPPLY_W  = 12;
   localparam int OFFSET_W  = 12;
   localparam int SLOPE_W   = 16;
   localparam int MASS_W    = 26;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   // Width of the supply times sample product.
   localparam int PROD_W = SUPPLY_W + SAMPLE_W;

   // The divider takes divisors up to the slope width.
   localparam int DIVISOR_W = SLOPE_W;

   // Full scale of the converter and the hundredths scale factor.
   localparam logic [DIVISOR_W-1:0] ADC_FULL_SCALE = 16'd4095;
   localparam logic [6:0]           CENTI_SCALE    = 7'd100;
   localparam int                   CENTI_W        = 7;

   // Reset values of the configuration registers.
   localparam logic [SUPPLY_W-1:0] SUPPLY_RESET = 12'd2800;
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 12'd0;
   localparam logic [SLOPE_W-1:0]  SLOPE_RESET  = 16'd260;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SUPPLY_MV      = 2'd0,
      CSR_ZERO_OFFSET_MV = 2'd1,
      CSR_SLOPE_CENTI    = 2'd2
   } csr_index_type;

endpackage

FILE: src/lcw_divider.sv
`timescale 1ns / 1ps

module lcw_divider #(
   parameter int DIVIDEND_W = 25,
   parameter int DIVISOR_W  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int COUNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [COUNT_W-1:0]    count_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  den_ff;

   logic [DIVISOR_W:0]    rem_shift;
   logic                  fits;
   logic [DIVISOR_W:0]    rem_diff;
   logic [DIVISOR_W-1:0]  rem_in;
   logic [DIVIDEND_W-1:0] quo_in;

   // One restoring step: bring down the next dividend bit and try a subtract.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIVIDEND_W-1]};
      rem_diff  = rem_shift - {1'b0, den_ff};
      fits      = (rem_shift >= {1'b0, den_ff});
      rem_in    = fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
      quo_in    = {quo_ff[DIVIDEND_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= COUNT_W'(DIVIDEND_W);
         end else if (busy_ff) begin
            count_ff <= count_ff - COUNT_W'(1);
            if (count_ff == COUNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: src/load_cell_trimmed_mean_weigher.sv
`timescale 1ns / 1ps

// Load cell weigher with a trimmed-mean moving-average filter. Each request carries one
// raw 12-bit converter reading, which is scaled to millivolts as
// floor(supply_mv * sample / 4095), reduced by the zero offset (clamped at zero) and
// stored in a window of WINDOW_LEN samples held in a single-port-write, registered-read
// memory. Every request gives exactly one result. While the window is still filling the
// result is a mass of zero with window_full low. Once it is full the window is read back
// entry by entry to form its sum, minimum and maximum; the sum less both extremes is
// turned into a mean in hundredths of a millivolt, divided by slope_centi and scaled to
// grams, so the mass is always a multiple of 100. One request is worked on at a time.
// The division by the converter full scale is a fold-and-correct step on the product,
// and the division by WINDOW_LEN - 2 is a multiplication by a fixed reciprocal; only the
// division by slope_centi uses the bit-serial divider, one quotient bit per cycle over
// DIV_W = 19 bits. A request taken while the window fills passes only through the
// multiply, fold, write and publish steps. With a full window the request also walks
// the memory (one entry per cycle), then forms the trimmed mean and runs the slope
// division. A finished result is held in the publish step while the output register
// is occupied and stalled, and then waits in that output register, so a new request is
// taken while the previous result is still pending. The window memory needs no
// clearing after reset: its entries are only read once every one of them has been
// written. Configuration is written through the csr_ port; the user must do so only
// while the block is idle, which the block itself does not enforce. An index beyond
// the three registers is ignored, and a slope of zero is treated as one.

module load_cell_trimmed_mean_weigher
   import lcw_pkg::*;
#(
   parameter int WINDOW_LEN = 48
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [SAMPLE_W-1:0]   req_adc_sample,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [MASS_W-1:0]     rsp_mass_grams,
   output logic                  rsp_window_full,

   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Widths that follow from the window length.
   localparam int ADDR_W      = $clog2(WINDOW_LEN);
   localparam int FILL_W      = $clog2(WINDOW_LEN + 1);
   localparam int SUM_W       = $clog2(WINDOW_LEN * 4095 + 1);
   localparam int TRIM_DIV_W  = SUM_W + CENTI_W;

   // The mean in hundredths of a millivolt never exceeds full scale times 100.
   localparam int DIV_W       = $clog2(int'(ADC_FULL_SCALE) * int'(CENTI_SCALE) + 1);

   // Reciprocal of WINDOW_LEN - 2. With the shift chosen as the dividend width plus the
   // bits of the divisor, the rounded-up reciprocal gives the exact floor quotient for
   // every dividend that fits in TRIM_DIV_W bits.
   localparam int TRIM_DIVISOR = WINDOW_LEN - 2;
   localparam int RECIP_SHIFT  = TRIM_DIV_W + $clog2(TRIM_DIVISOR);
   localparam int RECIP_W      = TRIM_DIV_W + 1;
   localparam int MEAN_PROD_W  = TRIM_DIV_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(TRIM_DIVISOR - 1)) / 64'(TRIM_DIVISOR));

   localparam logic [ADDR_W-1:0]    LAST_ADDR   = ADDR_W'(WINDOW_LEN - 1);
   localparam logic [FILL_W-1:0]    FILL_MAX    = FILL_W'(WINDOW_LEN);
   localparam logic [FILL_W-1:0]    FILL_LAST   = FILL_W'(WINDOW_LEN - 1);

   typedef enum logic [12:0] {
      ST_IDLE      = 13'b0000000000001,
      ST_MUL       = 13'b0000000000010,
      ST_MV_DIV    = 13'b0000000000100,
      ST_WRITE     = 13'b0000000001000,
      ST_WALK      = 13'b0000000010000,
      ST_TAIL      = 13'b0000000100000,
      ST_TRIM      = 13'b0000001000000,
      ST_TRIM_MUL  = 13'b0000010000000,
      ST_MEAN_DIV  = 13'b0000100000000,
      ST_SLOPE     = 13'b0001000000000,
      ST_SLOPE_DIV = 13'b0010000000000,
      ST_SCALE     = 13'b0100000000000,
      ST_PUBLISH   = 13'b1000000000000
   } state_type;

   // Configuration registers.
   logic [SUPPLY_W-1:0] supply_ff;
   logic [OFFSET_W-1:0] offset_ff;
   logic [SLOPE_W-1:0]  slope_ff;

   // Sequencer and window bookkeeping.
   state_type           state_ff, state_in;
   logic [FILL_W-1:0]   fill_ff;
   logic [ADDR_W-1:0]   wr_ptr_ff;
   logic [ADDR_W-1:0]   rd_addr_ff;
   logic                rd_valid_ff;

   // Working registers of the current request.
   logic [SAMPLE_W-1:0] sample_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [MV_W-1:0]     mv_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [MV_W-1:0]     lo_ff;
   logic [MV_W-1:0]     hi_ff;
   logic [SUM_W-1:0]    trim_ff;
   logic [TRIM_DIV_W-1:0]  trim_scaled_ff;
   logic [MEAN_PROD_W-1:0] mean_prod_ff;
   logic [MASS_W-1:0]   res_mass_ff;
   logic                res_full_ff;

   // Output register.
   logic                rsp_valid_ff;
   logic [MASS_W-1:0]   rsp_mass_ff;
   logic                rsp_full_ff;

   // Window memory and its registered read port.
   logic [MV_W-1:0]     window_mem [WINDOW_LEN];
   logic [MV_W-1:0]     rd_data_ff;

   // Divider hookup.
   logic                 div_start;
   logic [DIV_W-1:0]     div_dividend;
   logic [DIVISOR_W-1:0] div_divisor;
   logic                 div_done;
   logic [DIV_W-1:0]     div_quo;

   logic                 req_accept;
   logic                 rsp_free;
   logic [PROD_W-1:0]    prod;
   logic [MV_W:0]        mv_rem;
   logic [DIV_W+CENTI_W-1:0] mass_scaled;
   logic [MV_W-1:0]      scaled_mv;
   logic [MV_W-1:0]      bridge_mv;
   logic                 window_now_full;
   logic [SLOPE_W-1:0]   slope_safe;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign prod        = PROD_W'(supply_ff) * PROD_W'(sample_ff);
   assign mass_scaled = (DIV_W+CENTI_W)'(div_quo) * (DIV_W+CENTI_W)'(CENTI_SCALE);

   // Division by the full scale 4095 = 4096 - 1. Writing the product as q * 4096 + r
   // makes it q * 4095 + (q + r), and q + r stays below twice 4095, so the quotient is
   // q, plus one when q + r reaches 4095. The result never exceeds 4095.
   assign mv_rem    = {1'b0, prod_ff[MV_W-1:0]} + {1'b0, prod_ff[PROD_W-1 -: MV_W]};
   assign scaled_mv = prod_ff[PROD_W-1 -: MV_W]
                      + MV_W'(mv_rem >= (MV_W+1)'(ADC_FULL_SCALE));
   assign bridge_mv = (mv_ff > offset_ff) ? (mv_ff - offset_ff) : '0;

   // The window is full once this sample is counted.
   assign window_now_full = (fill_ff == FILL_LAST) || (fill_ff == FILL_MAX);

   assign slope_safe = (slope_ff == '0) ? SLOPE_W'(1) : slope_ff;

   // The divider only serves the slope division; the mean sits in the upper bits of the
   // reciprocal product.
   assign div_start    = (state_ff == ST_SLOPE);
   assign div_dividend = mean_prod_ff[RECIP_SHIFT +: DIV_W];
   assign div_divisor  = slope_safe;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_accept) state_in = ST_MUL;
         ST_MUL:       state_in = ST_MV_DIV;
         ST_MV_DIV:    state_in = ST_WRITE;
         ST_WRITE:     state_in = window_now_full ? ST_WALK : ST_PUBLISH;
         ST_WALK:      if (rd_addr_ff == LAST_ADDR) state_in = ST_TAIL;
         ST_TAIL:      state_in = ST_TRIM;
         ST_TRIM:      state_in = ST_TRIM_MUL;
         ST_TRIM_MUL:  state_in = ST_MEAN_DIV;
         ST_MEAN_DIV:  state_in = ST_SLOPE;
         ST_SLOPE:     state_in = ST_SLOPE_DIV;
         ST_SLOPE_DIV: if (div_done) state_in = ST_SCALE;
         ST_SCALE:     state_in = ST_PUBLISH;
         ST_PUBLISH:   if (rsp_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         wr_ptr_ff    <= '0;
         rd_addr_ff   <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         supply_ff    <= SUPPLY_RESET;
         offset_ff    <= OFFSET_RESET;
         slope_ff     <= SLOPE_RESET;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= (state_ff == ST_WALK);

         if (csr_write_en) begin
            case (csr_index)
               CSR_SUPPLY_MV:      supply_ff <= csr_wdata[SUPPLY_W-1:0];
               CSR_ZERO_OFFSET_MV: offset_ff <= csr_wdata[OFFSET_W-1:0];
               CSR_SLOPE_CENTI:    slope_ff  <= csr_wdata[SLOPE_W-1:0];
               default:            ;
            endcase
         end

         if (state_ff == ST_WRITE) begin
            wr_ptr_ff  <= (wr_ptr_ff == LAST_ADDR) ? '0 : wr_ptr_ff + ADDR_W'(1);
            rd_addr_ff <= '0;
            if (fill_ff != FILL_MAX) begin
               fill_ff <= fill_ff + FILL_W'(1);
            end
         end else if (state_ff == ST_WALK) begin
            rd_addr_ff <= rd_addr_ff + ADDR_W'(1);
         end

         if (state_ff == ST_PUBLISH && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Window memory: the new sample is written in its own cycle, and the walk reads the
   // entries back in the cycles after, so a read never meets a write to the same entry.
   always_ff @(posedge clock) begin
      if (state_ff == ST_WRITE) begin
         window_mem[wr_ptr_ff] <= bridge_mv;
      end
      rd_data_ff <= window_mem[rd_addr_ff];
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         sample_ff <= req_adc_sample;
      end

      if (state_ff == ST_MUL) begin
         prod_ff <= prod;
      end

      if (state_ff == ST_MV_DIV) begin
         mv_ff <= scaled_mv;
      end

      if (state_ff == ST_WRITE) begin
         sum_ff      <= '0;
         lo_ff       <= '1;
         hi_ff       <= '0;
         res_mass_ff <= '0;
         res_full_ff <= 1'b0;
      end else if (rd_valid_ff) begin
         sum_ff <= sum_ff + SUM_W'(rd_data_ff);
         if (rd_data_ff < lo_ff) lo_ff <= rd_data_ff;
         if (rd_data_ff > hi_ff) hi_ff <= rd_data_ff;
      end

      if (state_ff == ST_TRIM) begin
         trim_ff <= sum_ff - SUM_W'(lo_ff) - SUM_W'(hi_ff);
      end

      if (state_ff == ST_TRIM_MUL) begin
         trim_scaled_ff <= TRIM_DIV_W'(trim_ff) * TRIM_DIV_W'(CENTI_SCALE);
      end

      if (state_ff == ST_MEAN_DIV) begin
         mean_prod_ff <= MEAN_PROD_W'(trim_scaled_ff) * MEAN_PROD_W'(RECIP);
      end

      if (state_ff == ST_SCALE) begin
         res_mass_ff <= mass_scaled[MASS_W-1:0];
         res_full_ff <= 1'b1;
      end

      if (state_ff == ST_PUBLISH && rsp_free) begin
         rsp_mass_ff <= res_mass_ff;
         rsp_full_ff <= res_full_ff;
      end
   end

   lcw_divider #(
      .DIVIDEND_W (DIV_W),
      .DIVISOR_W  (DIVISOR_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mass_grams  = rsp_mass_ff;
   assign rsp_window_full = rsp_full_ff;

endmodule
